// ===== sv/swll_pkg.sv =====
// ----------------------------------------------------------------------------
// swll_pkg: shared types and constants
// Request kinds, register map, command/status structs and the size clamp.
// ----------------------------------------------------------------------------
package swll_pkg;

  localparam int DATA_W    = 16;
  localparam int IDX_W     = 5;
  localparam int SIZE_W    = 6;
  localparam int NI_W      = 5;
  localparam int ACC_W     = 40;
  localparam int ACC_DEPTH = 32;

  // request kinds (s_axis_tuser)
  localparam logic [1:0] KIND_FWD    = 2'd0;
  localparam logic [1:0] KIND_BWD    = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;
  localparam logic [1:0] KIND_BIAS   = 2'd3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_IN_SIZE  = 2'd0;
  localparam logic [1:0] REG_OUT_SIZE = 2'd1;
  localparam logic [1:0] REG_N_INST   = 2'd2;

  // effective sizes after clamping
  typedef struct packed {
    logic [SIZE_W-1:0] isz;
    logic [SIZE_W-1:0] osz;
    logic [NI_W-1:0]   ni;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic             wr_weight;
    logic             wr_bias;
    logic             load;
    logic             issue;
    logic             first;
    logic             fwd;
    logic [IDX_W-1:0] elem;
    logic [IDX_W-1:0] j;
    logic             emit_ld;
    logic             last_slice;
    logic             last_row;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
  } status_t;

  // 0 acts as 1, anything above lim acts as lim
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] lim);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

endpackage

// ===== sv/shared_weight_linear_layer.sv =====
// ----------------------------------------------------------------------------
// shared_weight_linear_layer: shared-weight fully connected layer
// One weight matrix and bias serve every slice of a row; forward and
// backward (transposed) passes, Q4.11 data, saturated results.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake          payload
// -------  ---  -----------------  ---------------------------------------
// s_axis   in   tvalid / tready    tuser: kind; tdata: row, col, value
// m_axis   out  tvalid / tready    tdata: out_value, out_index; tlast;
//                                  tuser: saturated, last_of_row
// apb      in   psel/penable/...   in_size, out_size, n_instances
//
// Sequence: a weight or bias write request is written as it is accepted. A
// data element is accepted, then the single MAC unit sweeps one weight per
// cycle over nout outputs (nout = out_size forward, in_size backward), then
// its read/multiply/accumulate pipeline drains. The slice's last element
// then emits nout results through the read, load and output states, each
// result held on any m_axis stall.
// Only one request is in work at a time; s_axis_tready is low meanwhile.
// Reset: synchronous, active high; clears counters, state machine and the
// accumulator written flags, so accumulators read as zero until written.
// Weight and bias RAMs are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
module shared_weight_linear_layer #(
  parameter int IN_DIM        = 32,
  parameter int OUT_DIM       = 32,
  parameter int MAX_INSTANCES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [4:0] row_index, [9:5] col_index, [25:10] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] out_value, [20:16] out_index
  output logic        m_axis_tlast,   // last_of_slice
  output logic [1:0]  m_axis_tuser,   // [0] saturated, [1] last_of_row
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  swll_pkg::cfg_t    cfg;
  swll_pkg::cmd_t    cmd;
  swll_pkg::status_t status;

  logic signed [15:0] out_value;
  logic [4:0]         out_index;
  logic               saturated;
  logic               last_of_slice;
  logic               last_of_row;

  // register file; sizes leave already clamped to their legal ranges
  swll_cfg #(
    .IN_DIM        (IN_DIM),
    .OUT_DIM       (OUT_DIM),
    .MAX_INSTANCES (MAX_INSTANCES)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: decodes each request, keeps slice/element position,
  // drops a partial slice when the pass direction changes
  swll_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .s_kind   (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .cfg      (cfg),
    .status   (status),
    .cmd      (cmd)
  );

  // storage, MAC pipeline and the output register
  swll_dp #(
    .IN_DIM  (IN_DIM),
    .OUT_DIM (OUT_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .row_index     (s_axis_tdata[4:0]),
    .col_index     (s_axis_tdata[9:5]),
    .value         ($signed(s_axis_tdata[25:10])),
    .cmd           (cmd),
    .status        (status),
    .out_value     (out_value),
    .out_index     (out_index),
    .saturated     (saturated),
    .last_of_slice (last_of_slice),
    .last_of_row   (last_of_row)
  );

  assign m_axis_tdata = {3'd0, out_index, out_value};
  assign m_axis_tlast = last_of_slice;
  assign m_axis_tuser = {last_of_row, saturated};

endmodule

// ===== sv/swll_ram.sv =====
// ----------------------------------------------------------------------------
// swll_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swll_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/swll_cfg.sv =====
// ----------------------------------------------------------------------------
// swll_cfg: APB register file
// Holds in_size, out_size, n_instances and hands out the clamped sizes.
// ----------------------------------------------------------------------------
module swll_cfg #(
  parameter int IN_DIM        = 32,
  parameter int OUT_DIM       = 32,
  parameter int MAX_INSTANCES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output swll_pkg::cfg_t     cfg
);

  localparam logic [5:0] IN_LIM  = 6'((IN_DIM < 32) ? IN_DIM : 32);
  localparam logic [5:0] OUT_LIM = 6'((OUT_DIM < 32) ? OUT_DIM : 32);
  localparam logic [5:0] NI_LIM  = 6'((MAX_INSTANCES < 16) ? MAX_INSTANCES : 16);

  logic [5:0] in_size;
  logic [5:0] out_size;
  logic [4:0] n_instances;
  logic       wr;
  logic [5:0] ni_clamped;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_size     <= 6'd32;
      out_size    <= 6'd32;
      n_instances <= 5'd1;
    end else if (wr) begin
      case (paddr[3:2])
        swll_pkg::REG_IN_SIZE:  in_size     <= pwdata[5:0];
        swll_pkg::REG_OUT_SIZE: out_size    <= pwdata[5:0];
        swll_pkg::REG_N_INST:   n_instances <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      swll_pkg::REG_IN_SIZE:  prdata = {26'd0, in_size};
      swll_pkg::REG_OUT_SIZE: prdata = {26'd0, out_size};
      swll_pkg::REG_N_INST:   prdata = {27'd0, n_instances};
      default:                prdata = '0;
    endcase
  end

  assign ni_clamped = swll_pkg::clamp_size({1'b0, n_instances}, NI_LIM);
  assign cfg.isz    = swll_pkg::clamp_size(in_size, IN_LIM);
  assign cfg.osz    = swll_pkg::clamp_size(out_size, OUT_LIM);
  assign cfg.ni     = ni_clamped[4:0];

endmodule

// ===== sv/swll_ctrl.sv =====
// ----------------------------------------------------------------------------
// swll_ctrl: layer sequencer
// Request decode, slice/element counters, MAC sweep, drain and result emit.
// ----------------------------------------------------------------------------
module swll_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [1:0]        s_kind,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  swll_pkg::cfg_t    cfg,
  input  swll_pkg::status_t status,
  output swll_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MAC      = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_EMIT_RD  = 3'd3;
  localparam logic [2:0] ST_EMIT_LD  = 3'd4;
  localparam logic [2:0] ST_EMIT_OUT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [4:0] element_count;
  logic [3:0] slice_count;
  logic       block_kind;
  logic [4:0] elem;
  logic [5:0] nout;
  logic       fwd;
  logic       first;
  logic       last_elem;
  logic       last_row;
  logic [4:0] j;
  logic [4:0] j_next;

  // accept-time decode
  logic       accept;
  logic       data_req;
  logic       changed;
  logic [4:0] ec_eff;
  logic [3:0] sc_eff;
  logic [5:0] len_a;
  logic [5:0] nout_a;
  logic [4:0] e_a;
  logic [5:0] e_p1;
  logic [4:0] sc_p1;
  logic       last_elem_a;
  logic       last_row_a;
  logic       j_last;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT_OUT);
  assign accept   = s_tvalid && s_tready;
  assign data_req = (s_kind == swll_pkg::KIND_FWD) || (s_kind == swll_pkg::KIND_BWD);
  assign changed  = (s_kind[0] != block_kind);
  assign ec_eff   = changed ? 5'd0 : element_count;
  assign sc_eff   = changed ? 4'd0 : slice_count;
  assign len_a    = (s_kind == swll_pkg::KIND_FWD) ? cfg.isz : cfg.osz;
  assign nout_a   = (s_kind == swll_pkg::KIND_FWD) ? cfg.osz : cfg.isz;
  // shrunk size: clip the element position to the slice's last
  assign e_a         = ({1'b0, ec_eff} >= len_a) ? 5'(len_a - 6'd1) : ec_eff;
  assign e_p1        = {1'b0, e_a} + 6'd1;
  assign last_elem_a = (e_p1 >= len_a);
  assign sc_p1       = {1'b0, sc_eff} + 5'd1;
  assign last_row_a  = (sc_p1 >= cfg.ni);
  assign j_last      = ({1'b0, j} == (nout - 6'd1));

  always_comb begin
    state_next = state;
    j_next     = j;
    case (state)
      ST_IDLE: begin
        if (accept && data_req) begin
          state_next = ST_MAC;
          j_next     = '0;
        end
      end
      ST_MAC: begin
        if (j_last) begin
          state_next = ST_DRAIN;
          j_next     = '0;
        end else begin
          j_next = j + 5'd1;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = last_elem ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_EMIT_RD:  state_next = ST_EMIT_LD;
      ST_EMIT_LD:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (m_tready) begin
          if (j_last) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
            j_next     = j + 5'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      element_count <= '0;
      slice_count   <= '0;
      block_kind    <= 1'b0;
      j             <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      if (accept && data_req) begin
        block_kind    <= s_kind[0];
        element_count <= last_elem_a ? 5'd0 : e_p1[4:0];
        if (last_elem_a) begin
          slice_count <= last_row_a ? 4'd0 : sc_p1[3:0];
        end else begin
          slice_count <= sc_eff;
        end
      end
    end
  end

  // per-request context
  always_ff @(posedge clk) begin
    if (accept && data_req) begin
      elem      <= e_a;
      nout      <= nout_a;
      fwd       <= (s_kind == swll_pkg::KIND_FWD);
      first     <= (e_a == 5'd0);
      last_elem <= last_elem_a;
      last_row  <= last_row_a;
    end
  end

  always_comb begin
    cmd.wr_weight  = accept && (s_kind == swll_pkg::KIND_WEIGHT);
    cmd.wr_bias    = accept && (s_kind == swll_pkg::KIND_BIAS);
    cmd.load       = accept && data_req;
    cmd.issue      = (state == ST_MAC);
    cmd.first      = first;
    cmd.fwd        = fwd;
    cmd.elem       = elem;
    cmd.j          = j;
    cmd.emit_ld    = (state == ST_EMIT_LD);
    cmd.last_slice = j_last;
    cmd.last_row   = j_last && last_row;
  end

endmodule

// ===== sv/swll_dp.sv =====
// ----------------------------------------------------------------------------
// swll_dp: layer datapath
// Weight/bias/accumulator RAMs, 3-stage MAC pipeline, round/saturate output.
// Accumulator entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module swll_dp #(
  parameter int IN_DIM  = 32,
  parameter int OUT_DIM = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [4:0]         row_index,
  input  logic [4:0]         col_index,
  input  logic signed [15:0] value,
  input  swll_pkg::cmd_t     cmd,
  output swll_pkg::status_t  status,
  output logic signed [15:0] out_value,
  output logic [4:0]         out_index,
  output logic               saturated,
  output logic               last_of_slice,
  output logic               last_of_row
);

  localparam int WDEPTH = IN_DIM * OUT_DIM;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int BAW    = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int AAW    = $clog2(swll_pkg::ACC_DEPTH);

  logic signed [15:0] value_q;
  logic [WAW-1:0]     w_wr_addr;
  logic [WAW-1:0]     w_rd_addr;
  logic               w_wr_en;
  logic               b_wr_en;
  logic [15:0]        w_rd;
  logic [15:0]        b_rd;
  logic [39:0]        acc_rd;
  logic               acc_wr_en;
  logic [39:0]        acc_wr_data;
  logic [swll_pkg::ACC_DEPTH-1:0] acc_written;

  // pipeline: stage 0 = read issued, stage 1 = product and base registered
  logic               vld0;
  logic               vld1;
  logic [4:0]         j0;
  logic [4:0]         j1;
  logic signed [31:0] prod;
  logic signed [39:0] base;
  logic signed [39:0] base_sel;

  // output rounding
  logic signed [40:0] rnd;
  logic signed [29:0] r;
  logic               sat_hi;
  logic               sat_lo;

  assign w_wr_en   = cmd.wr_weight && (int'(row_index) < IN_DIM)
                     && (int'(col_index) < OUT_DIM);
  assign b_wr_en   = cmd.wr_bias && (int'(col_index) < OUT_DIM);
  assign w_wr_addr = WAW'(int'(row_index) * OUT_DIM + int'(col_index));
  assign w_rd_addr = cmd.fwd ? WAW'(int'(cmd.elem) * OUT_DIM + int'(cmd.j))
                             : WAW'(int'(cmd.j) * OUT_DIM + int'(cmd.elem));

  swll_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_weight (
    .clk     (clk),
    .wr_en   (w_wr_en),
    .wr_addr (w_wr_addr),
    .wr_data (value),
    .rd_addr (w_rd_addr),
    .rd_data (w_rd)
  );

  swll_ram #(.WIDTH(16), .DEPTH(OUT_DIM)) u_bias (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (BAW'(col_index)),
    .wr_data (value),
    .rd_addr (BAW'(cmd.j)),
    .rd_data (b_rd)
  );

  swll_ram #(.WIDTH(swll_pkg::ACC_W), .DEPTH(swll_pkg::ACC_DEPTH)) u_acc (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (AAW'(j1)),
    .wr_data (acc_wr_data),
    .rd_addr (AAW'(cmd.j)),
    .rd_data (acc_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_q <= value;
    end
  end

  // one flag per accumulator: clear at reset, set on first write
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_written <= '0;
    end else if (acc_wr_en) begin
      acc_written[j1] <= 1'b1;
    end
  end

  // first element starts from the bias (forward) or zero (backward)
  always_comb begin
    if (cmd.first) begin
      base_sel = cmd.fwd ? {{13{b_rd[15]}}, b_rd, 11'd0} : 40'sd0;
    end else begin
      base_sel = acc_written[j0] ? $signed(acc_rd) : 40'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
    end else begin
      vld0 <= cmd.issue;
      vld1 <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    j0   <= cmd.j;
    j1   <= j0;
    prod <= value_q * $signed(w_rd);
    base <= base_sel;
  end

  assign acc_wr_en        = vld1;
  assign acc_wr_data      = base + {{8{prod[31]}}, prod};
  assign status.pipe_busy = vld0 || vld1;

  // round half up, floor shift by 11, clip to 16 bits
  assign rnd    = $signed({acc_rd[39], acc_rd}) + 41'sd1024;
  assign r      = rnd[40:11];
  assign sat_hi = (r > 30'sd32767);
  assign sat_lo = (r < -30'sd32768);

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      if (sat_hi) begin
        out_value <= 16'sh7FFF;
      end else if (sat_lo) begin
        out_value <= -16'sh8000;
      end else begin
        out_value <= r[15:0];
      end
      saturated     <= sat_hi || sat_lo;
      out_index     <= cmd.j;
      last_of_slice <= cmd.last_slice;
      last_of_row   <= cmd.last_row;
    end
  end

endmodule
